[hw/rtl/ubce_pkg.sv]
// ----------------------------------------------------------------------------
// ubce_pkg
// Shared types and constants of the serial boot command engine.
// ----------------------------------------------------------------------------
package ubce_pkg;

	localparam logic [7:0] ACK_BYTE  = 8'h79;
	localparam logic [7:0] NACK_BYTE = 8'h1F;
	localparam logic [7:0] SYNC_BYTE = 8'h7F;

	localparam logic [7:0] CMD_GET   = 8'hFF;
	localparam logic [7:0] CMD_VER   = 8'hFD;
	localparam logic [7:0] CMD_ID    = 8'hFB;
	localparam logic [7:0] CMD_READ  = 8'hDD;
	localparam logic [7:0] CMD_GO    = 8'hBD;
	localparam logic [7:0] CMD_WRITE = 8'h9D;
	localparam logic [7:0] CMD_ERASE = 8'h79;
	localparam logic [7:0] CMD_MAGIC = 8'h00;

	localparam logic [2:0] KIND_TX    = 3'd0;
	localparam logic [2:0] KIND_READ  = 3'd1;
	localparam logic [2:0] KIND_PROG  = 3'd2;
	localparam logic [2:0] KIND_ERASE = 3'd3;
	localparam logic [2:0] KIND_RESET = 3'd4;

	localparam logic [31:0] START_RESET = 32'h0800_1000;
	localparam logic [31:0] END_RESET   = 32'h0801_0000;

	// Reply tables, selected by the reply code and indexed by byte position.
	localparam logic [1:0] REPLY_GET = 2'd0;
	localparam logic [1:0] REPLY_VER = 2'd1;
	localparam logic [1:0] REPLY_ID  = 2'd2;

	function automatic logic [7:0] reply_byte(input logic [1:0] sel, input logic [3:0] idx);
		logic [7:0] r;
		r = 8'h00;
		unique case (sel)
			REPLY_GET: begin
				unique case (idx)
					4'd0: r = 8'h07;
					4'd1: r = 8'h10;
					4'd2: r = 8'h00;
					4'd3: r = 8'h01;
					4'd4: r = 8'h02;
					4'd5: r = 8'h11;
					4'd6: r = 8'h21;
					4'd7: r = 8'h31;
					4'd8: r = 8'h43;
					default: r = 8'h00;
				endcase
			end
			REPLY_VER: begin
				unique case (idx)
					4'd0: r = 8'h10;
					default: r = 8'h00;
				endcase
			end
			REPLY_ID: begin
				unique case (idx)
					4'd0: r = 8'h01;
					4'd1: r = 8'h04;
					4'd2: r = 8'h10;
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Command from the controller to the datapath.
	typedef struct packed {
		logic       clr_addr;    // clear address, check and counter
		logic       shift_addr;  // shift byte into address
		logic       xor_in;      // fold byte into the running check
		logic       load_len;    // load length byte
		logic       load_xor;    // load running check with byte
		logic       clr_cnt;
		logic       inc_cnt;
		logic       buf_wr;      // store byte in buffer at counter
		logic       load_first;
		logic       clr_all;
		logic       set_erase;
		logic       prog_start;  // start program scan
		logic       prog_next;   // advance to next group
		logic       rd_req;      // read a buffer lane
		logic [2:0] rd_lane;     // byte within the group, 0..7
	} ubce_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [7:0]  first_byte;
		logic [8:0]  cnt;
		logic [7:0]  len;
		logic [7:0]  xor_val;
		logic        erase_latched;
		logic [31:0] addr;
		logic [7:0]  rd_byte;     // registered buffer read
		logic [3:0]  grp_mask;    // mask of current group
		logic        grp_any;     // current group has lanes
		logic [31:0] grp_addr;
	} ubce_stat_t;

endpackage

[hw/rtl/ubce_datapath.sv]
// ----------------------------------------------------------------------------
// ubce_datapath
// Address, length, check and counter registers, the write buffer and the
// group scan for flash programming.
// ----------------------------------------------------------------------------
module ubce_datapath #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       din,
	input  ubce_pkg::ubce_cmd_t  cmd,
	input  logic [31:0]      region_start,
	input  logic [31:0]      region_end,
	output ubce_pkg::ubce_stat_t stat
);
	import ubce_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);

	logic [7:0]  first_q, len_q, xor_q;
	logic [8:0]  cnt_q;
	logic [31:0] addr_q;
	logic        erase_q;
	logic [7:0]  mem [BUFFER_BYTES];
	logic [7:0]  rd_q;
	logic        rd_ok_q;

	// Group scan: position of the current group in halfwords and its address.
	logic [7:0]  grp_hw_q;   // first halfword index of the group
	logic [31:0] grp_addr_q;
	logic [7:0]  hw_total;   // halfwords minus one
	logic [3:0]  mask_c;
	logic        stop_q;     // an earlier halfword was out of range or outside the region

	assign hw_total = {1'b0, len_q[7:1]};

	// Per lane: halfword index within range count and address inside region.
	always_comb begin
		logic        stop;
		logic [31:0] a;
		logic [8:0]  j;
		stop = stop_q;
		mask_c = '0;
		for (int i = 0; i < 4; i++) begin
			a = grp_addr_q + 32'(2 * i);
			j = {1'b0, grp_hw_q} + 9'(i);
			if (j > {1'b0, hw_total} || a < region_start || a >= region_end)
				stop = 1'b1;
			mask_c[i] = !stop;
		end
	end

	// Buffer read: index = group halfword * 2 + lane byte.
	logic [8:0] rd_idx;
	assign rd_idx = {grp_hw_q, 1'b0} + 9'(cmd.rd_lane);

	always_ff @(posedge clk) begin
		if (cmd.buf_wr && cnt_q < 9'(BUFFER_BYTES))
			mem[cnt_q[AW-1:0]] <= din;
		if (cmd.rd_req)
			rd_q <= mem[rd_idx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0; len_q <= '0; xor_q <= '0; cnt_q <= '0;
			addr_q <= '0; erase_q <= 1'b0; rd_ok_q <= 1'b0;
			grp_hw_q <= '0; grp_addr_q <= '0; stop_q <= 1'b0;
		end else begin
			if (cmd.rd_req)
				rd_ok_q <= rd_idx <= {1'b0, len_q} && rd_idx < 9'(BUFFER_BYTES);
			if (cmd.clr_all) begin
				first_q <= '0; len_q <= '0; xor_q <= '0; cnt_q <= '0;
				addr_q <= '0; erase_q <= 1'b0;
			end else begin
				if (cmd.load_first)
					first_q <= din;
				if (cmd.clr_addr) begin
					addr_q <= '0;
					xor_q <= '0;
				end else if (cmd.shift_addr)
					addr_q <= {addr_q[23:0], din};
				if (cmd.load_xor)
					xor_q <= din;
				else if (cmd.xor_in)
					xor_q <= xor_q ^ din;
				if (cmd.load_len)
					len_q <= din;
				if (cmd.clr_cnt || cmd.clr_addr)
					cnt_q <= '0;
				else if (cmd.inc_cnt)
					cnt_q <= cnt_q + 9'd1;
				if (cmd.set_erase)
					erase_q <= 1'b1;
			end
			if (cmd.prog_start) begin
				grp_hw_q <= '0;
				grp_addr_q <= addr_q;
				stop_q <= 1'b0;
			end else if (cmd.prog_next) begin
				grp_hw_q <= grp_hw_q + 8'd4;
				grp_addr_q <= grp_addr_q + 32'd8;
				stop_q <= !mask_c[3];
			end
		end
	end

	assign stat.first_byte    = first_q;
	assign stat.cnt           = cnt_q;
	assign stat.len           = len_q;
	assign stat.xor_val       = xor_q;
	assign stat.erase_latched = erase_q;
	assign stat.addr          = addr_q;
	assign stat.rd_byte       = rd_ok_q ? rd_q : 8'hFF;
	assign stat.grp_mask      = mask_c;
	assign stat.grp_any       = mask_c[0] && (grp_hw_q <= hw_total) && !(grp_hw_q[7:2] == 6'h3F && 1'b0);
	assign stat.grp_addr      = grp_addr_q;

endmodule

[hw/rtl/ubce_ctrl.sv]
// ----------------------------------------------------------------------------
// ubce_ctrl
// Command state machine; sequences result items into the output register.
// ----------------------------------------------------------------------------
module ubce_ctrl #(
	parameter int MAGIC_SKIP_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_type,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  o_kind,
	output logic [7:0]  o_tx,
	output logic [31:0] o_addr,
	output logic [63:0] o_data,
	output logic [3:0]  o_mask,
	output logic        o_last,
	output ubce_pkg::ubce_cmd_t  cmd,
	input  ubce_pkg::ubce_stat_t stat
);
	import ubce_pkg::*;

	// Protocol phases.
	localparam logic [4:0] PH_IDLE = 5'd0, PH_CMD2 = 5'd1, PH_RM_ADDR = 5'd2,
		PH_RM_LEN = 5'd3, PH_RM_CS = 5'd4, PH_RM_DATA = 5'd5, PH_GO_ADDR = 5'd6,
		PH_WM_ADDR = 5'd7, PH_WM_LEN = 5'd8, PH_WM_DATA = 5'd9, PH_WM_CS = 5'd10,
		PH_ER_COUNT = 5'd11, PH_ER_LIST = 5'd12, PH_ER_GLOBAL = 5'd13,
		PH_MAGIC = 5'd14;

	// Sequencer steps.
	localparam logic [3:0] SQ_IN = 4'd0, SQ_REPLY = 4'd1, SQ_RD2 = 4'd2,
		SQ_ERASE = 4'd3, SQ_FIN_ACK = 4'd4, SQ_PSCAN = 4'd5, SQ_PLANE = 4'd6,
		SQ_PEMIT = 4'd7, SQ_RESET = 4'd8, SQ_WAIT = 4'd9;

	logic [4:0]  phase_q;
	logic [3:0]  sq_q;
	logic [1:0]  rsel_q;
	logic [3:0]  ridx_q, rlen_q;
	logic [2:0]  lane_q;
	logic [63:0] pdata_q;
	logic [8:0]  rcnt_q;

	logic        ov_q;
	logic [2:0]  kind_q;
	logic [7:0]  tx_q;
	logic [31:0] addr_q;
	logic [63:0] data_q;
	logic [3:0]  mask_q;
	logic        last_q;

	logic [4:0]  n_phase;
	logic [3:0]  n_sq, n_ridx, n_rlen;
	logic [1:0]  n_rsel;
	logic [2:0]  n_lane, n_k;
	logic [63:0] n_pdata, pmasked;
	logic [7:0]  n_t;
	logic [8:0]  n_rcnt;
	logic        n_emit, n_l;
	logic [31:0] n_a;

	logic free;
	assign free     = !ov_q || out_ready;
	assign in_ready = sq_q == SQ_IN && free;
	assign out_valid = ov_q;
	assign o_kind = kind_q; assign o_tx = tx_q; assign o_addr = addr_q;
	assign o_data = data_q; assign o_mask = mask_q; assign o_last = last_q;

	logic acc;
	assign acc = in_valid && in_ready;

	logic [7:0] diff;
	assign diff = in_byte - stat.first_byte;

	// Next-state logic: emit at most one result item per cycle.
	always_comb begin
		logic       emit;
		logic [2:0] k;
		logic [7:0] t;
		logic [31:0] a;
		logic       l;
		cmd = '0;
		emit = 1'b0; k = KIND_TX; t = 8'h00; a = '0; l = 1'b0;
		cmd.rd_lane = lane_q;
		n_phase = phase_q; n_sq = sq_q; n_rsel = rsel_q; n_ridx = ridx_q;
		n_rlen = rlen_q; n_lane = lane_q; n_pdata = pdata_q;
		n_rcnt = rcnt_q;
		unique case (sq_q)
			SQ_IN: begin
				if (acc) begin
					if (phase_q == PH_RM_DATA) begin
						if (in_type) begin
							emit = 1'b1; t = in_byte;
							if (rcnt_q + 9'd1 <= {1'b0, stat.len}) begin
								n_rcnt = rcnt_q + 9'd1;
								n_sq = SQ_RD2;
							end else begin
								l = 1'b1;
								n_phase = PH_IDLE;
							end
						end
					end else if (!in_type) begin
						priority case (phase_q)
							PH_IDLE: begin
								if (in_byte == SYNC_BYTE) begin
									emit = 1'b1; t = ACK_BYTE; l = 1'b1;
								end else begin
									cmd.load_first = 1'b1;
									n_phase = PH_CMD2;
								end
							end
							PH_CMD2: begin
								n_phase = PH_IDLE;
								emit = 1'b1; t = ACK_BYTE; l = 1'b1;
								priority case (diff)
									CMD_GET: begin
										l = 1'b0; n_sq = SQ_REPLY; n_rsel = REPLY_GET;
										n_ridx = '0; n_rlen = 4'd9;
									end
									CMD_VER: begin
										l = 1'b0; n_sq = SQ_REPLY; n_rsel = REPLY_VER;
										n_ridx = '0; n_rlen = 4'd3;
									end
									CMD_ID: begin
										l = 1'b0; n_sq = SQ_REPLY; n_rsel = REPLY_ID;
										n_ridx = '0; n_rlen = 4'd3;
									end
									CMD_READ: begin
										cmd.clr_addr = 1'b1; n_phase = PH_RM_ADDR;
									end
									CMD_GO: begin
										cmd.clr_addr = 1'b1; n_phase = PH_GO_ADDR;
									end
									CMD_WRITE: begin
										cmd.clr_addr = 1'b1; n_phase = PH_WM_ADDR;
									end
									CMD_ERASE: n_phase = PH_ER_COUNT;
									CMD_MAGIC: begin
										emit = 1'b0; cmd.clr_cnt = 1'b1; n_phase = PH_MAGIC;
									end
									default: t = NACK_BYTE;
								endcase
							end
							PH_RM_ADDR, PH_GO_ADDR, PH_WM_ADDR: begin
								cmd.xor_in = 1'b1;
								if (stat.cnt < 9'd4) begin
									cmd.shift_addr = 1'b1; cmd.inc_cnt = 1'b1;
								end else if (phase_q == PH_GO_ADDR) begin
									emit = 1'b1; t = ACK_BYTE; n_sq = SQ_RESET;
								end else if ((stat.xor_val ^ in_byte) != 8'h00) begin
									emit = 1'b1; t = NACK_BYTE; l = 1'b1; n_phase = PH_IDLE;
								end else begin
									emit = 1'b1; t = ACK_BYTE; l = 1'b1;
									n_phase = (phase_q == PH_RM_ADDR) ? PH_RM_LEN : PH_WM_LEN;
								end
							end
							PH_RM_LEN: begin
								cmd.load_len = 1'b1; n_phase = PH_RM_CS;
							end
							PH_RM_CS: begin
								emit = 1'b1; t = ACK_BYTE; n_rcnt = '0; cmd.clr_cnt = 1'b1;
								n_sq = SQ_RD2; n_phase = PH_RM_DATA;
							end
							PH_WM_LEN: begin
								cmd.load_len = 1'b1; cmd.load_xor = 1'b1; cmd.clr_cnt = 1'b1;
								n_phase = PH_WM_DATA;
							end
							PH_WM_DATA: begin
								cmd.buf_wr = 1'b1; cmd.xor_in = 1'b1; cmd.inc_cnt = 1'b1;
								if (stat.cnt + 9'd1 > {1'b0, stat.len})
									n_phase = PH_WM_CS;
							end
							PH_WM_CS: begin
								n_phase = PH_IDLE;
								if ((stat.xor_val ^ in_byte) != 8'h00) begin
									emit = 1'b1; t = NACK_BYTE; l = 1'b1;
								end else begin
									cmd.prog_start = 1'b1; n_sq = SQ_PSCAN;
								end
							end
							PH_ER_COUNT: begin
								if (in_byte == 8'hFF)
									n_phase = PH_ER_GLOBAL;
								else begin
									cmd.load_len = 1'b1; cmd.load_xor = 1'b1;
									cmd.clr_cnt = 1'b1; n_phase = PH_ER_LIST;
								end
							end
							PH_ER_LIST: begin
								cmd.xor_in = 1'b1; cmd.inc_cnt = 1'b1;
								if (stat.cnt + 9'd1 >= {1'b0, stat.len} + 9'd2) begin
									n_phase = PH_IDLE;
									if ((stat.xor_val ^ in_byte) != 8'h00) begin
										emit = 1'b1; t = NACK_BYTE; l = 1'b1;
									end else
										n_sq = SQ_ERASE;
								end
							end
							PH_ER_GLOBAL: begin
								n_phase = PH_IDLE; n_sq = SQ_ERASE;
							end
							PH_MAGIC: begin
								cmd.inc_cnt = 1'b1;
								if (stat.cnt + 9'd1 >= 9'(MAGIC_SKIP_BYTES))
									n_phase = PH_IDLE;
							end
							default: n_phase = PH_IDLE;
						endcase
					end
				end
			end
			SQ_REPLY: if (free) begin
				emit = 1'b1;
				if (ridx_q == rlen_q) begin
					t = ACK_BYTE; l = 1'b1; n_sq = SQ_IN;
				end else begin
					t = reply_byte(rsel_q, ridx_q);
					n_ridx = ridx_q + 4'd1;
				end
			end
			SQ_RD2: if (free) begin
				emit = 1'b1; k = KIND_READ; l = 1'b1;
				a = stat.addr + 32'(rcnt_q); n_sq = SQ_IN;
			end
			SQ_RESET: if (free) begin
				emit = 1'b1; k = KIND_RESET; l = 1'b1;
				cmd.clr_all = 1'b1; n_phase = PH_IDLE; n_sq = SQ_IN;
			end
			SQ_ERASE: if (free) begin
				emit = 1'b1;
				if (!stat.erase_latched) begin
					k = KIND_ERASE; cmd.set_erase = 1'b1;
				end else begin
					t = ACK_BYTE; l = 1'b1; n_sq = SQ_IN;
				end
			end
			SQ_PSCAN: begin
				if (stat.grp_any) begin
					n_lane = 3'd0; cmd.rd_req = 1'b1; cmd.rd_lane = 3'd0;
					n_sq = SQ_PLANE;
				end else
					n_sq = SQ_FIN_ACK;
			end
			SQ_PLANE: begin
				// Read data of lane_q arrives now; collect it.
				n_pdata = pdata_q;
				n_pdata[8*lane_q +: 8] = stat.rd_byte;
				if (lane_q == 3'd7)
					n_sq = SQ_PEMIT;
				else begin
					n_lane = lane_q + 3'd1;
					cmd.rd_req = 1'b1; cmd.rd_lane = lane_q + 3'd1;
				end
			end
			SQ_PEMIT: if (free) begin
				emit = 1'b1; k = KIND_PROG; a = stat.grp_addr;
				cmd.prog_next = 1'b1; n_sq = SQ_PSCAN;
			end
			SQ_FIN_ACK: if (free) begin
				emit = 1'b1; t = ACK_BYTE; l = 1'b1; n_sq = SQ_IN;
			end
			default: n_sq = SQ_IN;
		endcase
		n_emit = emit; n_k = k; n_t = t; n_a = a; n_l = l;
	end

	// Lanes outside the mask read as erased halfwords.
	always_comb begin
		for (int i = 0; i < 4; i++)
			pmasked[16*i +: 16] = stat.grp_mask[i] ? pdata_q[16*i +: 16] : 16'hFFFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; sq_q <= SQ_IN; ov_q <= 1'b0;
			rcnt_q <= '0;
		end else begin
			phase_q <= n_phase; sq_q <= n_sq; rcnt_q <= n_rcnt;
			if (n_emit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rsel_q <= n_rsel; ridx_q <= n_ridx; rlen_q <= n_rlen; lane_q <= n_lane;
		pdata_q <= n_pdata;
		if (n_emit) begin
			kind_q <= n_k; tx_q <= n_t; addr_q <= n_a; last_q <= n_l;
			data_q <= (n_k == KIND_PROG) ? pmasked : 64'd0;
			mask_q <= (n_k == KIND_PROG) ? stat.grp_mask : 4'd0;
		end
	end

`ifndef SYNTHESIS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sq_q != SQ_IN |-> !in_ready) else $error("input taken while sequencing");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_prog_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && o_kind == KIND_PROG |-> o_mask != 4'd0) else $error("empty group");
`endif

endmodule

[hw/rtl/uart_boot_command_engine_unit.sv]
// ----------------------------------------------------------------------------
// uart_boot_command_engine_unit
// Serial boot loader command engine: decodes received bytes into replies,
// memory reads, flash program groups, erase and reset requests.
// ----------------------------------------------------------------------------
// Each accepted input item is one received serial byte or one byte returned
// from a memory read. The engine answers with zero to 33 result items, the
// final one flagged by tlast. Results leave through a one-item output
// register, one per cycle while the sink is ready, and no new input is taken
// until every result of the current item has been produced. A write command
// ends with a program scan that reads the buffer one byte per cycle; each
// group of four halfwords takes one scan step, eight buffer reads and one
// emit. The buffer read port sets the pace of the scan. The write buffer
// holds no reset value; only bytes written by the current write command
// are ever read.
module uart_boot_command_engine_unit #(
	parameter int BUFFER_BYTES     = 256,
	parameter int MAGIC_SKIP_BYTES = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // tx_byte, target_address, program_data, lane_mask, pad
	output logic [2:0]   m_tuser,   // out_kind
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import ubce_pkg::*;

	logic [31:0] start_q, end_q;
	ubce_cmd_t  cmd;
	ubce_stat_t stat;
	logic [7:0]  tx;
	logic [31:0] ta;
	logic [63:0] pd;
	logic [3:0]  lm;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			end_q   <= END_RESET;
		end else if (cfg_valid) begin
			if (cfg_index) end_q <= cfg_data;
			else           start_q <= cfg_data;
		end
	end

	ubce_ctrl #(.MAGIC_SKIP_BYTES(MAGIC_SKIP_BYTES)) u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready), .in_type(s_tuser), .in_byte(s_tdata),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.o_kind(m_tuser), .o_tx(tx), .o_addr(ta), .o_data(pd), .o_mask(lm),
		.o_last(m_tlast), .cmd, .stat
	);

	ubce_datapath #(.BUFFER_BYTES(BUFFER_BYTES)) u_dp (
		.clk, .arst_n, .din(s_tdata), .cmd,
		.region_start(start_q), .region_end(end_q), .stat
	);

	assign m_tdata = {4'd0, lm, pd, ta, tx};

endmodule

[bench/ubce_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubce_checker
// Watches the input, output and register channels of the boot command engine,
// predicts the result items of every accepted input item and compares them.
// ----------------------------------------------------------------------------
module ubce_checker
	import ubce_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic [2:0]   m_tuser,
	input  logic         m_tlast,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CMD2, ST_RM_ADDR, ST_RM_LEN, ST_RM_CS, ST_RM_DATA, ST_GO_ADDR,
		ST_WM_ADDR, ST_WM_LEN, ST_WM_DATA, ST_WM_CS, ST_ER_COUNT, ST_ER_LIST,
		ST_ER_GLOBAL, ST_MAGIC
	} eng_state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  tx;
		logic [31:0] addr;
		logic [63:0] data;
		logic [3:0]  mask;
		logic        last;
	} result_t;

	localparam int BUF_BYTES  = 256;
	localparam int SKIP_BYTES = 12;

	result_t     expected_results[$];
	logic [31:0] reg_start, reg_end;
	eng_state_t  st;
	logic [7:0]  first_b, len_b, chk;
	logic [8:0]  cnt;
	logic [31:0] addr_acc;
	logic [7:0]  wbuf[BUF_BYTES];
	logic        erased;

	assign pending = expected_results.size();

	task automatic push_result(input logic [2:0] kind, input logic [7:0] tx,
			input logic [31:0] addr, input logic [63:0] data, input logic [3:0] mask);
		result_t r;
		r.kind = kind; r.tx = tx; r.addr = addr; r.data = data; r.mask = mask; r.last = 1'b0;
		expected_results.push_back(r);
	endtask

	task automatic push_reply(input logic [7:0] tbl[], input int len);
		push_result(KIND_TX, ACK_BYTE, 0, 0, 0);
		for (int i = 0; i < len; i++) push_result(KIND_TX, tbl[i], 0, 0, 0);
		push_result(KIND_TX, ACK_BYTE, 0, 0, 0);
	endtask

	function automatic logic [7:0] stored_byte(input int idx);
		if (idx <= len_b && idx < BUF_BYTES) return wbuf[idx];
		return 8'hFF;
	endfunction

	task automatic program_groups();
		int k;
		logic [31:0] a;
		logic [63:0] d;
		logic [3:0]  m;
		int hw;
		k = 0;
		a = addr_acc;
		hw = (len_b >> 1) + 1;
		while (k < hw && a >= reg_start && a < reg_end) begin
			k++;
			a += 2;
		end
		for (int g = 0; g * 4 < k; g++) begin
			d = '1;
			m = '0;
			for (int i = 0; i < 4; i++) begin
				if (g * 4 + i < k) begin
					d[16*i +: 16] = {stored_byte(2*(g*4+i)+1), stored_byte(2*(g*4+i))};
					m[i] = 1'b1;
				end
			end
			push_result(KIND_PROG, 0, addr_acc + 32'(8 * g), d, m);
		end
	endtask

	task automatic do_erase();
		if (!erased) begin
			push_result(KIND_ERASE, 0, 0, 0, 0);
			erased = 1'b1;
		end
		push_result(KIND_TX, ACK_BYTE, 0, 0, 0);
		st = ST_IDLE;
	endtask

	task automatic clear_engine();
		st = ST_IDLE; first_b = 0; cnt = 0; addr_acc = 0; chk = 0; len_b = 0; erased = 0;
	endtask

	// Apply one input item to the predicted engine state.
	task automatic predict_item(input logic rt, input logic [7:0] b);
		int prior_count;
		logic [7:0] get_tbl[] = '{8'h07, 8'h10, 8'h00, 8'h01, 8'h02, 8'h11, 8'h21,
			8'h31, 8'h43};
		logic [7:0] ver_tbl[] = '{8'h10, 8'h00, 8'h00};
		logic [7:0] id_tbl[]  = '{8'h01, 8'h04, 8'h10};
		prior_count = expected_results.size();
		if (st == ST_RM_DATA) begin
			if (rt) begin
				push_result(KIND_TX, b, 0, 0, 0);
				cnt++;
				if (cnt <= len_b) push_result(KIND_READ, 0, addr_acc + 32'(cnt), 0, 0);
				else st = ST_IDLE;
			end
		end else if (!rt) begin
			case (st)
				ST_IDLE: begin
					if (b == SYNC_BYTE) push_result(KIND_TX, ACK_BYTE, 0, 0, 0);
					else begin
						first_b = b;
						st = ST_CMD2;
					end
				end
				ST_CMD2: begin
					st = ST_IDLE;
					case (8'(b - first_b))
						CMD_GET: push_reply(get_tbl, 9);
						CMD_VER: push_reply(ver_tbl, 3);
						CMD_ID: push_reply(id_tbl, 3);
						CMD_READ, CMD_GO, CMD_WRITE: begin
							push_result(KIND_TX, ACK_BYTE, 0, 0, 0);
							addr_acc = 0; chk = 0; cnt = 0;
							st = (8'(b - first_b) == CMD_READ) ? ST_RM_ADDR :
								(8'(b - first_b) == CMD_GO) ? ST_GO_ADDR : ST_WM_ADDR;
						end
						CMD_ERASE: begin
							push_result(KIND_TX, ACK_BYTE, 0, 0, 0);
							st = ST_ER_COUNT;
						end
						CMD_MAGIC: begin
							cnt = 0;
							st = ST_MAGIC;
						end
						default: push_result(KIND_TX, NACK_BYTE, 0, 0, 0);
					endcase
				end
				ST_RM_ADDR, ST_GO_ADDR, ST_WM_ADDR: begin
					chk ^= b;
					if (cnt < 4) begin
						addr_acc = {addr_acc[23:0], b};
						cnt++;
					end else if (st == ST_GO_ADDR) begin
						push_result(KIND_TX, ACK_BYTE, 0, 0, 0);
						push_result(KIND_RESET, 0, 0, 0, 0);
						clear_engine();
					end else if (chk != 0) begin
						push_result(KIND_TX, NACK_BYTE, 0, 0, 0);
						st = ST_IDLE;
					end else begin
						push_result(KIND_TX, ACK_BYTE, 0, 0, 0);
						st = (st == ST_RM_ADDR) ? ST_RM_LEN : ST_WM_LEN;
					end
				end
				ST_RM_LEN: begin
					len_b = b;
					st = ST_RM_CS;
				end
				ST_RM_CS: begin
					push_result(KIND_TX, ACK_BYTE, 0, 0, 0);
					cnt = 0;
					push_result(KIND_READ, 0, addr_acc, 0, 0);
					st = ST_RM_DATA;
				end
				ST_WM_LEN: begin
					len_b = b; chk = b; cnt = 0;
					st = ST_WM_DATA;
				end
				ST_WM_DATA: begin
					if (cnt < BUF_BYTES) wbuf[cnt] = b;
					chk ^= b;
					cnt++;
					if (cnt > len_b) st = ST_WM_CS;
				end
				ST_WM_CS: begin
					chk ^= b;
					if (chk != 0) push_result(KIND_TX, NACK_BYTE, 0, 0, 0);
					else begin
						program_groups();
						push_result(KIND_TX, ACK_BYTE, 0, 0, 0);
					end
					st = ST_IDLE;
				end
				ST_ER_COUNT: begin
					if (b == 8'hFF) st = ST_ER_GLOBAL;
					else begin
						len_b = b; chk = b; cnt = 0;
						st = ST_ER_LIST;
					end
				end
				ST_ER_LIST: begin
					chk ^= b;
					cnt++;
					if (cnt >= len_b + 9'd2) begin
						if (chk != 0) begin
							push_result(KIND_TX, NACK_BYTE, 0, 0, 0);
							st = ST_IDLE;
						end else do_erase();
					end
				end
				ST_ER_GLOBAL: do_erase();
				ST_MAGIC: begin
					cnt++;
					if (cnt >= SKIP_BYTES) st = ST_IDLE;
				end
				default: st = ST_IDLE;
			endcase
		end
		if (expected_results.size() > prior_count)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, exp_r;
		if (!arst_n) begin
			reg_start = START_RESET;
			reg_end = END_RESET;
			clear_engine();
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index) reg_end = cfg_data;
				else reg_start = cfg_data;
			end
			// Compare the output first, so an item taken this edge never races it.
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[103:40],
					m_tdata[107:104], m_tlast};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result item kind=%0d data=%h last=%b",
						$time, m_tuser, m_tdata, m_tlast);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got != exp_r) begin
						$display("%0t: mismatch expected kind=%0d tx=%h addr=%h data=%h mask=%h last=%b",
							$time, exp_r.kind, exp_r.tx, exp_r.addr, exp_r.data, exp_r.mask,
							exp_r.last);
						$display("%0t:          actual   kind=%0d tx=%h addr=%h data=%h mask=%h last=%b",
							$time, got.kind, got.tx, got.addr, got.data, got.mask, got.last);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
		end
	end

endmodule

[bench/tb_uart_boot_command_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_boot_command_engine_unit
// Stimulus and verdict for the serial boot command engine. Directed command
// sequences come first, then random well-formed commands mixed with noise,
// under several idling phases and register settings. The checker module
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_uart_boot_command_engine_unit;
	import ubce_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_index = 1'b0;
	logic [31:0]  cfg_data = '0;
	int           fail_count;
	int           pending;

	// Idling knobs: percent of cycles in which the sender or receiver idles.
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_off = 1'b0;
	int  cycle_count = 0;

	// Count of input items accepted so far; it paces the random phases.
	int  items_sent = 0;

	localparam int CYCLE_LIMIT = 1500000;

	always #6 clk = ~clk;

	uart_boot_command_engine_unit dut (.*);

	ubce_checker checker_i (.*);

	// Receiver: stalls at random, or for a long stretch when asked.
	always @(posedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offer one item and hold it until it is accepted. Valid stays high into
	// the next item; it drops on an idle cycle or when the stream pauses.
	task automatic send_item(input logic rt, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rt;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(1'b0, b);
	endtask

	task automatic send_cmd(input logic [7:0] code);
		logic [7:0] f;
		f = 8'($urandom_range(255));
		if (f == SYNC_BYTE) f = 8'h80;
		send_byte(f);
		send_byte(8'(f + code));
	endtask

	// Address bytes most significant first, then the check, good or spoiled.
	task automatic send_addr(input logic [31:0] a, input bit good);
		logic [7:0] x;
		x = a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0];
		for (int i = 3; i >= 0; i--) send_byte(a[8*i +: 8]);
		send_byte(good ? x : ~x);
	endtask

	task automatic do_read(input logic [31:0] a, input logic [7:0] n);
		send_cmd(CMD_READ);
		send_addr(a, 1'b1);
		send_byte(n);
		send_byte(~n);
		for (int i = 0; i <= n; i++) begin
			if ($urandom_range(9) == 0) send_item(1'b0, 8'($urandom_range(255)));
			send_item(1'b1, 8'($urandom_range(255)));
		end
	endtask

	task automatic do_write(input logic [31:0] a, input logic [7:0] n, input bit good);
		logic [7:0] x;
		logic [7:0] d;
		send_cmd(CMD_WRITE);
		send_addr(a, 1'b1);
		send_byte(n);
		x = n;
		for (int i = 0; i <= n; i++) begin
			d = 8'($urandom_range(255));
			x ^= d;
			send_byte(d);
		end
		send_byte(good ? x : ~x);
	endtask

	task automatic do_erase(input logic [7:0] n, input bit good);
		logic [7:0] x;
		logic [7:0] d;
		send_cmd(CMD_ERASE);
		send_byte(n);
		if (n == 8'hFF) send_byte(8'($urandom_range(255)));
		else begin
			x = n;
			for (int i = 0; i < n + 2; i++) begin
				d = (i == n + 1) ? x : 8'($urandom_range(255));
				x ^= d;
				if (i == n + 1 && !good) d = ~d;
				send_byte(d);
			end
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] near_region(input logic [31:0] s);
		return s - 32'($urandom_range(16)) * 2 + 32'($urandom_range(1));
	endfunction

	// One random command: mostly well-formed, sometimes noise or broken.
	task automatic random_command(input logic [31:0] s);
		int pick;
		pick = $urandom_range(19);
		case (pick)
			0: send_byte(SYNC_BYTE);
			1: send_cmd(CMD_GET);
			2: send_cmd(CMD_VER);
			3: send_cmd(CMD_ID);
			4, 5: do_read($urandom, 8'($urandom_range(6)));
			6, 7, 8, 9: do_write(($urandom_range(3) == 0) ? $urandom : near_region(s),
				($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(20)),
				$urandom_range(5) != 0);
			10, 11: do_erase(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(4)),
				$urandom_range(3) != 0);
			12: begin
				send_cmd(CMD_MAGIC);
				repeat (12) send_byte(8'($urandom_range(255)));
			end
			13: begin
				send_cmd(CMD_WRITE);
				send_addr($urandom, 1'b0);
			end
			14: send_item(1'b1, 8'($urandom_range(255)));
			15: begin
				send_cmd(CMD_GO);
				send_addr($urandom, 1'($urandom_range(1)));
			end
			default: begin
				send_byte(8'($urandom_range(255)));
				send_byte(8'($urandom_range(255)));
			end
		endcase
	endtask

	initial begin
		logic [31:0] s;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sync, each reply, unknown command, wrong request type.
		send_byte(SYNC_BYTE);
		send_cmd(CMD_GET);
		send_cmd(CMD_VER);
		send_cmd(CMD_ID);
		send_cmd(8'h42);
		send_item(1'b1, 8'hA5);
		// Read with address wrap and, at random, stray serial bytes during the read.
		do_read(32'hFFFF_FFFE, 8'd3);
		// Odd tail write inside the region, then one running off its end.
		do_write(START_RESET, 8'd4, 1'b1);
		do_write(END_RESET - 4, 8'd9, 1'b1);
		do_write(START_RESET, 8'd2, 1'b0);
		send_cmd(CMD_READ);
		send_addr(32'h1234_5678, 1'b0);
		do_erase(8'd1, 1'b0);
		do_erase(8'hFF, 1'b1);
		do_erase(8'd0, 1'b1);
		send_cmd(CMD_MAGIC);
		repeat (12) send_byte(8'hFF);
		send_cmd(CMD_GO);
		send_addr(32'h0800_0000, 1'b0);
		do_write(START_RESET - 2, 8'd255, 1'b1);
		do_erase(8'd2, 1'b1);
		wait_drained();

		// Random phases under several idling patterns and region settings.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			case (ph)
				1: s = 32'h0;
				3: s = 32'hFFFF_FFF0;
				default: s = $urandom;
			endcase
			write_reg(1'b0, s);
			write_reg(1'b1, (ph == 1) ? 32'h0 : (ph == 3) ? 32'hFFFF_FFFF :
				s + 32'($urandom_range(64)));
			if (ph == 5) begin
				// Long receiver hold-off while items keep coming.
				fork
					begin
						hold_off = 1'b1;
						repeat (400) @(posedge clk);
						hold_off = 1'b0;
					end
					begin
						send_cmd(CMD_GET);
						do_write(s, 8'd31, 1'b1);
						send_cmd(CMD_ID);
						s_tvalid <= 1'b0;
						@(posedge clk);
					end
				join
			end
			while (items_sent < 380 + 11 * (ph + 1)) random_command(s);
			wait_drained();
		end

		write_reg(1'b0, START_RESET);
		write_reg(1'b1, END_RESET);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
